@@ rtl/htdr_pkg.sv @@
`default_nettype none

package htdr_pkg;

   // Table geometry: slot index is the low key bits
   localparam int INDEX_W = 16;
   localparam int ENTRIES = 1 << INDEX_W;

   localparam logic [30:0] MATE_BOUND_RESET = 31'd31000;

   // Request modes
   localparam logic [2:0] MODE_STORE        = 3'd0;
   localparam logic [2:0] MODE_PROBE_SEARCH = 3'd1;
   localparam logic [2:0] MODE_PROBE_EVAL   = 3'd2;
   localparam logic [2:0] MODE_PROBE_RAW    = 3'd3;
   localparam logic [2:0] MODE_CLEAR        = 3'd4;

   localparam logic [1:0] KIND_EXACT = 2'd0;

   // Replacement bias: new depth + DEPTH_BONUS + PV_BONUS*pv > old depth - AGE_MARGIN
   localparam int DEPTH_BONUS = 7;
   localparam int PV_BONUS    = 2;
   localparam int AGE_MARGIN  = 4;

   typedef struct packed {
      logic [63:0]        key;
      logic signed [15:0] depth;
      logic signed [31:0] score;
      logic [1:0]         kind;
      logic [15:0]        move;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_CLEAR
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic accept;
      logic commit;
      logic clear_step;
   } ctrl_type;

   // Status from datapath to controller
   typedef struct packed {
      logic is_clear;
      logic rsp_free;
      logic clear_last;
   } status_type;

endpackage

`default_nettype wire

@@ rtl/htdr_ctrl.sv @@
`default_nettype none

module htdr_ctrl
   import htdr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire status_type status,
   output ctrl_type        ctrl
);

   state_type state_ff;
   state_type state_in;

   // Hold state; start with a clearing sweep after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequence: take a request, evaluate the slot, sweep on clear
   always_comb begin
      state_in        = state_ff;
      ctrl            = '0;
      req_stall       = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            ctrl.accept = req_valid;
            if (req_valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.rsp_free) begin
               ctrl.commit = 1'b1;
               state_in    = status.is_clear ? ST_CLEAR : ST_IDLE;
            end
         end
         ST_CLEAR: begin
            ctrl.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/htdr_datapath.sv @@
`default_nettype none

module htdr_datapath
   import htdr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ctrl_type           ctrl,
   output status_type              status,
   input  wire logic               csr_write_enable,
   input  wire logic [30:0]        csr_write_data,
   input  wire logic [2:0]         req_mode,
   input  wire logic [63:0]        req_key,
   input  wire logic signed [15:0] req_depth,
   input  wire logic signed [31:0] req_score,
   input  wire logic [7:0]         req_ply,
   input  wire logic [15:0]        req_move_word,
   input  wire logic               req_pv_flag,
   input  wire logic [1:0]         req_kind,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_found,
   output logic signed [15:0]      rsp_hit_depth,
   output logic signed [31:0]      rsp_hit_score,
   output logic [1:0]              rsp_hit_kind,
   output logic [15:0]             rsp_hit_move,
   output logic                    rsp_stored
);

   entry_type          mem [ENTRIES];
   entry_type          slot_ff;

   logic [30:0]        mate_bound_ff;
   logic [2:0]         mode_ff;
   logic [63:0]        key_ff;
   logic signed [15:0] depth_ff;
   logic signed [31:0] score_ff;
   logic [7:0]         ply_ff;
   logic [15:0]        move_ff;
   logic               pv_ff;
   logic [1:0]         kind_ff;
   logic [INDEX_W-1:0] clr_cnt_ff;

   logic               rsp_valid_ff;
   logic               found_ff;
   logic signed [15:0] hit_depth_ff;
   logic signed [31:0] hit_score_ff;
   logic [1:0]         hit_kind_ff;
   logic [15:0]        hit_move_ff;
   logic               stored_ff;

   logic               is_store;
   logic               key_hit;
   logic signed [17:0] new_rank;
   logic signed [17:0] old_rank;
   logic               replace;
   logic               write_slot;
   logic signed [31:0] shift_in;
   logic signed [31:0] shifted;
   logic               found_in;
   logic signed [31:0] hit_score_in;
   entry_type          wr_data;
   logic [INDEX_W-1:0] wr_addr;
   logic               wr_en;

   // Push a mate score away from zero by ply (away) or pull it back, saturating
   function automatic logic signed [31:0] mate_shift(input logic signed [31:0] s,
                                                     input logic [30:0] mb,
                                                     input logic [7:0] ply,
                                                     input logic away);
      logic signed [33:0] sx;
      logic signed [33:0] mbx;
      logic signed [33:0] px;
      logic signed [33:0] v;
      sx  = {{2{s[31]}}, s};
      mbx = {3'b000, mb};
      px  = {26'd0, ply};
      v   = sx;
      if (sx < -mbx) begin
         v = away ? sx - px : sx + px;
      end else if (sx > mbx) begin
         v = away ? sx + px : sx - px;
      end
      if (v > 34'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -34'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // Hold the mate bound register
   always_ff @(posedge clock) begin
      if (reset) begin
         mate_bound_ff <= MATE_BOUND_RESET;
      end else if (csr_write_enable) begin
         mate_bound_ff <= csr_write_data;
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         mode_ff  <= req_mode;
         key_ff   <= req_key;
         depth_ff <= req_depth;
         score_ff <= req_score;
         ply_ff   <= req_ply;
         move_ff  <= req_move_word;
         pv_ff    <= req_pv_flag;
         kind_ff  <= req_kind;
      end
   end

   // Evaluate the slot read on the accept edge
   always_comb begin
      is_store = (mode_ff == MODE_STORE);
      key_hit  = (slot_ff.key == key_ff);
      new_rank = 18'(depth_ff) + 18'(DEPTH_BONUS) + (pv_ff ? 18'(PV_BONUS) : 18'sd0);
      old_rank = 18'(slot_ff.depth) - 18'(AGE_MARGIN);
      replace  = (kind_ff == KIND_EXACT) || !key_hit || (new_rank > old_rank);
      write_slot = is_store && replace;

      // One shift unit serves the store and the search and eval probes; raw probes bypass it
      shift_in = is_store ? score_ff : slot_ff.score;
      shifted  = mate_shift(shift_in, mate_bound_ff, ply_ff, is_store);

      found_in     = 1'b0;
      hit_score_in = shifted;
      case (mode_ff)
         MODE_PROBE_SEARCH: found_in = key_hit && (slot_ff.depth >= depth_ff) && (ply_ff != 8'd0);
         MODE_PROBE_EVAL:   found_in = key_hit;
         MODE_PROBE_RAW: begin
            found_in     = key_hit;
            hit_score_in = slot_ff.score;
         end
         default: found_in = 1'b0;
      endcase

      wr_data.key   = key_ff;
      wr_data.depth = depth_ff;
      wr_data.score = shifted;
      wr_data.kind  = kind_ff;
      wr_data.move  = move_ff;
      wr_addr       = key_ff[INDEX_W-1:0];
      wr_en         = 1'b0;
      if (ctrl.clear_step) begin
         wr_data = '0;
         wr_addr = clr_cnt_ff;
         wr_en   = 1'b1;
      end else if (ctrl.commit && write_slot) begin
         wr_en = 1'b1;
      end
   end

   // Table memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctrl.accept) begin
         slot_ff <= mem[req_key[INDEX_W-1:0]];
      end
   end

   // Advance the clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (ctrl.clear_step) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   // Response register: load on commit, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.commit) begin
         found_ff     <= found_in;
         hit_depth_ff <= found_in ? slot_ff.depth : 16'sd0;
         hit_score_ff <= found_in ? hit_score_in : 32'sd0;
         hit_kind_ff  <= found_in ? slot_ff.kind : 2'd0;
         hit_move_ff  <= found_in ? slot_ff.move : 16'd0;
         stored_ff    <= write_slot;
      end
   end

   assign status.is_clear   = (mode_ff == MODE_CLEAR);
   assign status.rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign status.clear_last = (clr_cnt_ff == INDEX_W'(ENTRIES - 1));

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = found_ff;
   assign rsp_hit_depth = hit_depth_ff;
   assign rsp_hit_score = hit_score_ff;
   assign rsp_hit_kind  = hit_kind_ff;
   assign rsp_hit_move  = hit_move_ff;
   assign rsp_stored    = stored_ff;

endmodule

`default_nettype wire

@@ rtl/hash_table_with_depth_replacement.sv @@
`default_nettype none

// Channel   Direction  Handshake                 Payload
// req_      in         req_valid / req_stall     mode key depth score ply move_word pv_flag kind
// rsp_      out        rsp_valid / rsp_stall     found hit_depth hit_score hit_kind hit_move stored
// csr_      in         csr_write_enable          csr_write_data (mate bound, 31 bits)
//
// A request reads its slot from the table memory on the accept edge; the commit edge, taken
// once the response register is free, evaluates it, writes the slot back and loads the
// response register. A clear request, and reset, sweep the table's 65536 slots one slot a
// cycle, during which no request is accepted. Reset is synchronous and active high.
// A stalled response holds the evaluation, and no further request is accepted meanwhile.

module hash_table_with_depth_replacement
   import htdr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_enable,
   input  wire logic [30:0]        csr_write_data,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_mode,
   input  wire logic [63:0]        req_key,
   input  wire logic signed [15:0] req_depth,
   input  wire logic signed [31:0] req_score,
   input  wire logic [7:0]         req_ply,
   input  wire logic [15:0]        req_move_word,
   input  wire logic               req_pv_flag,
   input  wire logic [1:0]         req_kind,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_found,
   output logic signed [15:0]      rsp_hit_depth,
   output logic signed [31:0]      rsp_hit_score,
   output logic [1:0]              rsp_hit_kind,
   output logic [15:0]             rsp_hit_move,
   output logic                    rsp_stored
);

   ctrl_type   ctrl;
   status_type status;

   htdr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .ctrl      (ctrl)
   );

   htdr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_mode         (req_mode),
      .req_key          (req_key),
      .req_depth        (req_depth),
      .req_score        (req_score),
      .req_ply          (req_ply),
      .req_move_word    (req_move_word),
      .req_pv_flag      (req_pv_flag),
      .req_kind         (req_kind),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_hit_depth    (rsp_hit_depth),
      .rsp_hit_score    (rsp_hit_score),
      .rsp_hit_kind     (rsp_hit_kind),
      .rsp_hit_move     (rsp_hit_move),
      .rsp_stored       (rsp_stored)
   );

endmodule

`default_nettype wire

@@ tb/hash_table_with_depth_replacement_tb.sv @@
module hash_table_with_depth_replacement_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import htdr_pkg::*;

   localparam int RESET_CYCLES   = 10;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 200000;
   localparam int PHASES         = 5;
   localparam int PHASE_ITEMS    = 290;
   localparam int MAX_CLEARS     = 4;
   localparam int LONG_HOLD_AT   = 700;
   localparam int LONG_HOLD_LEN  = 150;
   localparam int KEY_POOL_SIZE  = 16;
   localparam int MAX_PRINTED    = 50;

   localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [2:0] MODE_SPARE_MID   = 3'd6;
   localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;
   localparam logic [1:0] KIND_UPPER = 2'd1;
   localparam logic [1:0] KIND_LOWER = 2'd2;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   localparam longint SCORE_MAX = 64'sd2147483647;
   localparam longint SCORE_MIN = -64'sd2147483648;

   typedef struct packed {
      logic [2:0]         mode;
      logic [63:0]        key;
      logic signed [15:0] depth;
      logic signed [31:0] score;
      logic [7:0]         ply;
      logic [15:0]        move_word;
      logic               pv_flag;
      logic [1:0]         kind;
   } table_request_type;

   typedef struct packed {
      logic               found;
      logic signed [15:0] hit_depth;
      logic signed [31:0] hit_score;
      logic [1:0]         hit_kind;
      logic [15:0]        hit_move;
      logic               stored;
   } table_reply_type;

   // DUT ports
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write_enable = 1'b0;
   logic [30:0]        csr_write_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_mode = MODE_STORE;
   logic [63:0]        req_key = '0;
   logic signed [15:0] req_depth = '0;
   logic signed [31:0] req_score = '0;
   logic [7:0]         req_ply = '0;
   logic [15:0]        req_move_word = '0;
   logic               req_pv_flag = 1'b0;
   logic [1:0]         req_kind = KIND_EXACT;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_found;
   logic signed [15:0] rsp_hit_depth;
   logic signed [31:0] rsp_hit_score;
   logic [1:0]         rsp_hit_kind;
   logic [15:0]        rsp_hit_move;
   logic               rsp_stored;

   // Model of the table and its register
   entry_type      slot_table [int unsigned];
   longint         mate_bound_model = MATE_BOUND_RESET;

   table_request_type pending_requests [$];
   table_reply_type   awaited_replies [$];
   table_request_type offered_request;
   logic [63:0]       key_pool [KEY_POOL_SIZE];

   int requests_queued   = 0;
   int requests_accepted = 0;
   int replies_seen      = 0;
   int error_count       = 0;
   int clears_issued     = 0;
   int req_gap_left      = 0;
   int rsp_hold_left     = 0;
   int quiet_cycles      = 0;
   bit req_no_idle       = 1'b0;
   bit rsp_no_idle       = 1'b0;

   hash_table_with_depth_replacement dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_key          (req_key),
      .req_depth        (req_depth),
      .req_score        (req_score),
      .req_ply          (req_ply),
      .req_move_word    (req_move_word),
      .req_pv_flag      (req_pv_flag),
      .req_kind         (req_kind),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_hit_depth    (rsp_hit_depth),
      .rsp_hit_score    (rsp_hit_score),
      .rsp_hit_kind     (rsp_hit_kind),
      .rsp_hit_move     (rsp_hit_move),
      .rsp_stored       (rsp_stored)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Push a mate score away from zero (dir +1) or pull it back (dir -1), saturating
   function automatic logic signed [31:0] shift_mate_score(logic signed [31:0] s,
                                                           logic [7:0] ply, int dir);
      longint v;
      longint p;
      v = s;
      p = ply;
      if (v < -mate_bound_model) v = v - dir * p;
      else if (v > mate_bound_model) v = v + dir * p;
      if (v > SCORE_MAX) v = SCORE_MAX;
      if (v < SCORE_MIN) v = SCORE_MIN;
      return v[31:0];
   endfunction

   // Apply one request to the table model and return the reply it causes
   function automatic table_reply_type table_lookup_update(table_request_type rq);
      table_reply_type rp;
      entry_type       slot;
      int unsigned     idx;
      logic            hit;
      rp  = '0;
      hit = 1'b0;
      idx = 32'(rq.key[INDEX_W-1:0]);
      slot = slot_table.exists(idx) ? slot_table[idx] : '0;
      case (rq.mode) inside
         MODE_STORE: begin
            if (rq.kind == KIND_EXACT || slot.key != rq.key ||
                longint'(rq.depth) + DEPTH_BONUS + PV_BONUS * longint'(rq.pv_flag) >
                longint'(slot.depth) - AGE_MARGIN) begin
               slot.key   = rq.key;
               slot.depth = rq.depth;
               slot.score = shift_mate_score(rq.score, rq.ply, 1);
               slot.kind  = rq.kind;
               slot.move  = rq.move_word;
               slot_table[idx] = slot;
               rp.stored = 1'b1;
            end
         end
         MODE_CLEAR: begin
            slot_table.delete();
         end
         MODE_PROBE_SEARCH, MODE_PROBE_EVAL, MODE_PROBE_RAW: begin
            if (slot.key == rq.key) begin
               if (rq.mode == MODE_PROBE_SEARCH)
                  hit = (longint'(slot.depth) >= longint'(rq.depth)) && (rq.ply != 8'd0);
               else
                  hit = 1'b1;
            end
            if (hit) begin
               rp.found     = 1'b1;
               rp.hit_depth = slot.depth;
               rp.hit_score = (rq.mode == MODE_PROBE_RAW) ? slot.score :
                              shift_mate_score(slot.score, rq.ply, -1);
               rp.hit_kind  = slot.kind;
               rp.hit_move  = slot.move;
            end
         end
         default: begin
         end
      endcase
      return rp;
   endfunction

   // Draw a score: near the mate bound, near the 32-bit limits, or anywhere
   function automatic logic signed [31:0] random_score();
      longint v;
      int     pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         v = mate_bound_model + longint'($urandom_range(0, 300)) - 150;
         if ($urandom_range(0, 1)) v = -v;
      end else if (pick < 55) begin
         v = $urandom_range(0, 300);
         v = $urandom_range(0, 1) ? SCORE_MAX - v : SCORE_MIN + v;
      end else begin
         v = longint'($signed($urandom));
      end
      if (v > SCORE_MAX) v = SCORE_MAX;
      if (v < SCORE_MIN) v = SCORE_MIN;
      return v[31:0];
   endfunction

   function automatic table_request_type random_request();
      table_request_type rq;
      int pick;
      pick = $urandom_range(0, 99);
      if (clears_issued < MAX_CLEARS && $urandom_range(0, 249) == 0) begin
         rq.mode = MODE_CLEAR;
         clears_issued++;
      end else if (pick < 40) rq.mode = MODE_STORE;
      else if (pick < 58) rq.mode = MODE_PROBE_SEARCH;
      else if (pick < 74) rq.mode = MODE_PROBE_EVAL;
      else if (pick < 93) rq.mode = MODE_PROBE_RAW;
      else rq.mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
      // most keys come from a small pool so that probes hit and stores collide
      if ($urandom_range(0, 99) < 85) rq.key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
      else rq.key = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 70) rq.depth = 16'($urandom_range(0, 50) - 10);
      else if (pick < 80) rq.depth = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      else rq.depth = 16'($urandom);
      rq.score     = random_score();
      rq.ply       = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
      rq.move_word = 16'($urandom);
      rq.pv_flag   = 1'($urandom_range(0, 1));
      rq.kind      = 2'($urandom_range(KIND_EXACT, KIND_SPARE));
      return rq;
   endfunction

   task automatic queue_fields(logic [2:0] mode, logic [63:0] key, logic signed [15:0] depth,
                               logic signed [31:0] score, logic [7:0] ply,
                               logic [15:0] move_word, logic pv_flag, logic [1:0] kind);
      table_request_type rq;
      rq.mode      = mode;
      rq.key       = key;
      rq.depth     = depth;
      rq.score     = score;
      rq.ply       = ply;
      rq.move_word = move_word;
      rq.pv_flag   = pv_flag;
      rq.kind      = kind;
      pending_requests.push_back(rq);
      requests_queued++;
   endtask

   // Hold off until every request is taken and every reply has come back
   task automatic wait_for_drain();
      while (requests_accepted != requests_queued || awaited_replies.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (error_count < MAX_PRINTED)
         $display("reply %0d: %s is %0h, expected %0h", replies_seen, what, got, want);
      error_count++;
   endtask

   // Request driver: present the next pending request after its drawn gap
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            awaited_replies.push_back(table_lookup_update(offered_request));
            requests_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (req_gap_left > 0) begin
               req_gap_left--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               offered_request = pending_requests.pop_front();
               req_mode      <= offered_request.mode;
               req_key       <= offered_request.key;
               req_depth     <= offered_request.depth;
               req_score     <= offered_request.score;
               req_ply       <= offered_request.ply;
               req_move_word <= offered_request.move_word;
               req_pv_flag   <= offered_request.pv_flag;
               req_kind      <= offered_request.kind;
               req_valid     <= 1'b1;
               if ($urandom_range(0, 29) == 0) req_no_idle = !req_no_idle;
               req_gap_left = req_no_idle ? 0 : $urandom_range(0, 14);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Reply monitor: check each accepted reply against the oldest prediction
   always @(posedge clock) begin
      table_reply_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_replies.size() == 0) begin
               report_mismatch("reply with nothing awaited, found", 64'(rsp_found), 64'd0);
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_found !== want.found)
                  report_mismatch("found", 64'(rsp_found), 64'(want.found));
               if (rsp_hit_depth !== want.hit_depth)
                  report_mismatch("hit_depth", 64'(rsp_hit_depth), 64'(want.hit_depth));
               if (rsp_hit_score !== want.hit_score)
                  report_mismatch("hit_score", 64'(rsp_hit_score), 64'(want.hit_score));
               if (rsp_hit_kind !== want.hit_kind)
                  report_mismatch("hit_kind", 64'(rsp_hit_kind), 64'(want.hit_kind));
               if (rsp_hit_move !== want.hit_move)
                  report_mismatch("hit_move", 64'(rsp_hit_move), 64'(want.hit_move));
               if (rsp_stored !== want.stored)
                  report_mismatch("stored", 64'(rsp_stored), 64'(want.stored));
            end
            replies_seen++;
            if ($urandom_range(0, 29) == 0) rsp_no_idle = !rsp_no_idle;
            rsp_hold_left = rsp_no_idle ? 0 : $urandom_range(0, 14);
            // one long hold-off so the block backs up and stalls requests
            if (replies_seen == LONG_HOLD_AT) rsp_hold_left = LONG_HOLD_LEN;
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: give up after a long stretch with no handshake on either side
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles++;
      end
   end

   initial begin
      logic [63:0] k1;
      logic [63:0] k1_alias;
      logic [63:0] k2;
      logic [30:0] phase_bounds [PHASES];

      for (int i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
      for (int i = 8; i < 12; i++)
         key_pool[i] = {$urandom, 16'($urandom), key_pool[i - 8][15:0]};
      key_pool[12] = '0;
      key_pool[13][15:0] = '0;
      key_pool[14] = '1;
      key_pool[15][15:0] = '1;

      phase_bounds[0] = '0;
      phase_bounds[1] = '1;
      phase_bounds[2] = 31'd1000;
      phase_bounds[3] = 31'($urandom_range(0, 32'h7FFF_FFFF));
      phase_bounds[4] = MATE_BOUND_RESET;

      k1       = 64'h0123_4567_89AB_CDEF;
      k1_alias = k1 ^ 64'h0000_0100_0000_0000;
      k2       = 64'hFEDC_BA98_7654_3210;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset value of the mate bound
      // key zero hits the cleared slots
      queue_fields(MODE_PROBE_RAW, '0, 16'sd0, 32'sd0, 8'd0, 16'h0, 1'b0, KIND_EXACT);
      queue_fields(MODE_PROBE_SEARCH, '0, 16'sd0, 32'sd0, 8'd1, 16'h0, 1'b0, KIND_EXACT);
      queue_fields(MODE_PROBE_SEARCH, '0, 16'sd0, 32'sd0, 8'd0, 16'h0, 1'b0, KIND_EXACT);
      // exact store at the field extremes, then a shallow bound that must not replace it
      queue_fields(MODE_STORE, k1, 16'sh7FFF, 32'sd31001, 8'd255, 16'hFFFF, 1'b1, KIND_EXACT);
      queue_fields(MODE_STORE, k1, 16'sh8000, 32'sd5, 8'd3, 16'h1234, 1'b1, KIND_LOWER);
      queue_fields(MODE_PROBE_SEARCH, k1, 16'sh8000, 32'sd0, 8'd255, 16'h0, 1'b0, KIND_EXACT);
      queue_fields(MODE_PROBE_EVAL, k1, 16'sd0, 32'sd0, 8'd10, 16'h0, 1'b0, KIND_EXACT);
      queue_fields(MODE_PROBE_RAW, k1, 16'sd0, 32'sd0, 8'd10, 16'h0, 1'b0, KIND_EXACT);
      // spare kind, deep enough to replace; score saturates at the negative limit
      queue_fields(MODE_STORE, k1, 16'sh7FFF, 32'sh8000_0000, 8'd200, 16'h0, 1'b0, KIND_SPARE);
      queue_fields(MODE_PROBE_EVAL, k1, 16'sd0, 32'sd0, 8'd0, 16'h0, 1'b0, KIND_EXACT);
      queue_fields(MODE_PROBE_EVAL, k1, 16'sd0, 32'sd0, 8'd255, 16'h0, 1'b0, KIND_EXACT);
      // same slot, different key: replaces; score saturates at the positive limit
      queue_fields(MODE_STORE, k1_alias, 16'sd5, 32'sh7FFF_FFFF, 8'd255, 16'hA5A5, 1'b0,
                   KIND_UPPER);
      queue_fields(MODE_PROBE_RAW, k1, 16'sd0, 32'sd0, 8'd0, 16'h0, 1'b0, KIND_EXACT);
      queue_fields(MODE_PROBE_SEARCH, k1_alias, 16'sd6, 32'sd0, 8'd3, 16'h0, 1'b0, KIND_EXACT);
      queue_fields(MODE_PROBE_SEARCH, k1_alias, 16'sd5, 32'sd0, 8'd3, 16'h0, 1'b0, KIND_EXACT);
      // replacement margin either side of the boundary
      queue_fields(MODE_STORE, k1_alias, -16'sd6, 32'sd1, 8'd0, 16'h1, 1'b0, KIND_LOWER);
      queue_fields(MODE_STORE, k1_alias, -16'sd8, 32'sd2, 8'd0, 16'h2, 1'b1, KIND_LOWER);
      queue_fields(MODE_STORE, k1_alias, -16'sd7, 32'sd3, 8'd0, 16'h3, 1'b1, KIND_LOWER);
      // scores on and just past the bound
      queue_fields(MODE_STORE, k2, 16'sd1, 32'sd31000, 8'd50, 16'h5A5A, 1'b0, KIND_EXACT);
      queue_fields(MODE_PROBE_EVAL, k2, 16'sd0, 32'sd0, 8'd50, 16'h0, 1'b0, KIND_EXACT);
      queue_fields(MODE_STORE, k2, 16'sd1, -32'sd31001, 8'd50, 16'h5A5A, 1'b0, KIND_EXACT);
      queue_fields(MODE_PROBE_EVAL, k2, 16'sd0, 32'sd0, 8'd20, 16'h0, 1'b0, KIND_EXACT);
      // spare modes do nothing
      queue_fields(MODE_SPARE_FIRST, k2, 16'sd3, 32'sd9, 8'd1, 16'h7, 1'b1, KIND_UPPER);
      queue_fields(MODE_SPARE_MID, k1, 16'sd3, 32'sd9, 8'd1, 16'h7, 1'b1, KIND_UPPER);
      queue_fields(MODE_SPARE_LAST, '1, 16'sd3, 32'sd9, 8'd1, 16'h7, 1'b1, KIND_SPARE);
      // clear, then the old entry is gone and key zero hits again
      queue_fields(MODE_CLEAR, '0, 16'sd0, 32'sd0, 8'd0, 16'h0, 1'b0, KIND_EXACT);
      queue_fields(MODE_PROBE_RAW, k1_alias, 16'sd0, 32'sd0, 8'd0, 16'h0, 1'b0, KIND_EXACT);
      queue_fields(MODE_PROBE_RAW, '0, 16'sd0, 32'sd0, 8'd0, 16'h0, 1'b0, KIND_EXACT);
      queue_fields(MODE_STORE, '1, 16'sd2, 32'sd7, 8'd1, 16'hFFFF, 1'b1, KIND_SPARE);
      queue_fields(MODE_PROBE_RAW, '1, 16'sd0, 32'sd0, 8'd0, 16'h0, 1'b0, KIND_EXACT);
      wait_for_drain();

      // Random phases, one mate bound each, written once the previous requests have drained
      for (int ph = 0; ph < PHASES; ph++) begin
         @(posedge clock);
         csr_write_enable <= 1'b1;
         csr_write_data   <= phase_bounds[ph];
         mate_bound_model = phase_bounds[ph];
         @(posedge clock);
         csr_write_enable <= 1'b0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pending_requests.push_back(random_request());
            requests_queued++;
         end
         wait_for_drain();
      end

      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/htdr_pkg.sv
rtl/htdr_ctrl.sv
rtl/htdr_datapath.sv
rtl/hash_table_with_depth_replacement.sv
tb/hash_table_with_depth_replacement_tb.sv
